// File: rtl/srss_pkg.sv
package srss_pkg;

    localparam int ROWS          = 256;
    localparam int SLOTS_PER_ROW = 8;

    localparam int ROW_W   = 9;
    localparam int COL_W   = 16;
    localparam int VAL_W   = 64;
    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W  = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [SLOTS_PER_ROW-1:0][COL_W-1:0] t_tag_row;
    typedef logic [SLOTS_PER_ROW-1:0][VAL_W-1:0] t_val_row;

    typedef struct packed {
        logic              operation;
        logic              in_range;
        logic [ROW_AW-1:0] row_addr;
        logic [COL_W-1:0]  column_index;
        logic [VAL_W-1:0]  element_value;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

    typedef enum logic {
        ST_ISSUE,
        ST_EXEC
    } t_back_state;

endpackage

// File: rtl/srss_req_if.sv
interface srss_req_if import srss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] column_index;
    logic [VAL_W-1:0] element_value;

    modport source (output valid, output operation, output row_index,
                    output column_index, output element_value, input ready);
    modport sink   (input valid, input operation, input row_index,
                    input column_index, input element_value, output ready);
endinterface

// File: rtl/srss_rsp_if.sv
interface srss_rsp_if import srss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] read_value;
    logic             row_overflow;

    modport source (output valid, output read_value, output row_overflow, input ready);
    modport sink   (input valid, input read_value, input row_overflow, output ready);
endinterface

// File: rtl/sparse_row_slot_store.sv
// each request is a read-modify-write of one row word in the tag and value
// memories (read, then compare and write); a new request is taken from the
// queue only when the last one is done and its result has been registered
// a two-entry request queue lets requests be taken while a result waits
// reset: synchronous, active low; per-row valid flags clear at once, so all
// slots read empty right after reset with no clearing pass
module sparse_row_slot_store import srss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srss_req_if.sink   i_req,
    srss_rsp_if.source o_rsp
);

    t_queue_out queue;
    logic       pop;

    srss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pop   (pop),
        .o_queue (queue)
    );

    srss_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_queue (queue),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

// File: rtl/srss_ram.sv
module srss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/srss_front.sv
module srss_front import srss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srss_req_if.sink   i_req,
    input  logic       i_pop,
    output t_queue_out o_queue
);

    t_item           r_queue [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic [Q_AW-1:0] n_wr_ptr;
    logic [Q_AW-1:0] n_rd_ptr;
    logic [Q_CW-1:0] n_count;

    t_item       in_item;
    logic [31:0] row_minus_one;
    logic        push;
    logic        pop;

    // classify: row out of range or empty-column tag gives a no-op request
    always_comb begin
        row_minus_one         = 32'(i_req.row_index) - 32'd1;
        in_item.operation     = i_req.operation;
        in_item.in_range      = (i_req.row_index != '0) &&
                                (32'(i_req.row_index) <= 32'(ROWS)) &&
                                (i_req.column_index != '0);
        in_item.row_addr      = row_minus_one[ROW_AW-1:0];
        in_item.column_index  = i_req.column_index;
        in_item.element_value = i_req.element_value;
    end

    assign i_req.ready = (r_count != Q_CW'(Q_DEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= in_item;
        end
    end

    assign o_queue.valid = (r_count != '0);
    assign o_queue.item  = r_queue[r_rd_ptr];

endmodule

// File: rtl/srss_back.sv
module srss_back import srss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_queue_out i_queue,
    output logic       o_pop,
    srss_rsp_if.source o_rsp
);

    t_back_state r_state;
    t_back_state n_state;

    t_item             r_item;
    logic              r_row_live;
    logic [ROWS-1:0]   r_row_valid;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_overflow;

    logic                     rd_en;
    logic                     wr_en;
    logic                     exec;
    logic                     out_free;
    logic [SLOTS_PER_ROW*COL_W-1:0] tag_rd;
    logic [SLOTS_PER_ROW*VAL_W-1:0] val_rd;
    t_tag_row                 tags;
    t_val_row                 vals;
    t_tag_row                 n_tags;
    t_val_row                 n_vals;
    logic [SLOT_W-1:0]        pos;
    logic                     found;
    logic                     hit;
    logic [VAL_W-1:0]         cur_value;
    logic [VAL_W-1:0]         res_value;
    logic                     res_overflow;

    srss_ram #(
        .WIDTH (SLOTS_PER_ROW * COL_W),
        .DEPTH (ROWS)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_item.row_addr),
        .i_wr_data (n_tags),
        .i_rd_en   (rd_en),
        .i_rd_addr (i_queue.item.row_addr),
        .o_rd_data (tag_rd)
    );

    srss_ram #(
        .WIDTH (SLOTS_PER_ROW * VAL_W),
        .DEPTH (ROWS)
    ) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_item.row_addr),
        .i_wr_data (n_vals),
        .i_rd_en   (rd_en),
        .i_rd_addr (i_queue.item.row_addr),
        .o_rd_data (val_rd)
    );

    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        exec    = 1'b0;
        unique case (r_state)
            ST_ISSUE: begin
                if (i_queue.valid) begin
                    o_pop   = 1'b1;
                    rd_en   = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    exec    = 1'b1;
                    n_state = ST_ISSUE;
                end
            end
            default: n_state = ST_ISSUE;
        endcase
    end

    // a row never written reads as all slots empty
    assign tags = r_row_live ? t_tag_row'(tag_rd) : '0;
    assign vals = t_val_row'(val_rd);

    always_comb begin
        pos   = '0;
        found = 1'b0;
        hit   = 1'b0;
        for (int s = SLOTS_PER_ROW - 1; s >= 0; s--) begin
            if ((tags[s] == '0) || (tags[s] == r_item.column_index)) begin
                pos   = SLOT_W'(s);
                found = 1'b1;
                hit   = (tags[s] != '0);
            end
        end
    end

    always_comb begin
        cur_value    = hit ? vals[pos] : '0;
        res_value    = '0;
        res_overflow = 1'b0;
        wr_en        = 1'b0;
        n_tags       = tags;
        n_vals       = vals;
        n_tags[pos]  = r_item.column_index;
        n_vals[pos]  = r_item.element_value;
        if (r_item.in_range) begin
            if (r_item.operation == OP_READ) begin
                res_value = cur_value;
            end else if (r_item.element_value != cur_value) begin
                if (found) begin
                    wr_en = exec;
                end else begin
                    res_overflow = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ISSUE;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_row_valid[r_item.row_addr] <= 1'b1;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_item     <= i_queue.item;
            r_row_live <= r_row_valid[i_queue.item.row_addr];
        end
        if (exec) begin
            r_out_value    <= res_value;
            r_out_overflow <= res_overflow;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.read_value   = r_out_value;
    assign o_rsp.row_overflow = r_out_overflow;

endmodule

// File: dv/tb_top.sv
module tb_top import srss_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 1900;
    localparam int IDLE_MAX   = 6;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 8;
    localparam int LIMIT      = 200000;
    localparam int N_HOT      = 6;
    localparam int HOT_COLS   = 12;
    localparam int TOTAL      = ROWS * SLOTS_PER_ROW;

    typedef struct {
        logic             op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] val;
    } t_elem_req;

    typedef struct {
        logic [VAL_W-1:0] read_value;
        logic             row_overflow;
    } t_elem_rsp;

    typedef struct {
        t_elem_req req;
        bit        typed;
        t_elem_rsp rsp;
    } t_elem_case;

    logic i_clk = 1'b0;
    logic i_rst_n;

    srss_req_if req_bus ();
    srss_rsp_if rsp_bus ();

    sparse_row_slot_store dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow copy of the slot store
    logic [COL_W-1:0] shadow_tags [TOTAL];
    logic [VAL_W-1:0] shadow_vals [TOTAL];

    t_elem_rsp  expected_rsp [$];
    t_elem_case directed_cases [$];
    int         n_fail     = 0;
    int         cycle_cnt  = 0;
    bit         calm       = 0;
    bit         hold_rsp   = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("[sparse_row_slot_store] ERROR");
            $finish;
        end
    end

    function automatic bit row_col_ok(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        return row != '0 && int'(row) <= ROWS && col != '0;
    endfunction

    // slot of the matching tag, else first empty slot, else SLOTS_PER_ROW
    function automatic int scan_row_slots(int base, logic [COL_W-1:0] col, output bit hit);
        hit = 0;
        for (int s = 0; s < SLOTS_PER_ROW; s++) begin
            if (shadow_tags[base + s] == '0) return s;
            if (shadow_tags[base + s] == col) begin
                hit = 1;
                return s;
            end
        end
        return SLOTS_PER_ROW;
    endfunction

    function automatic logic [VAL_W-1:0] stored_value(logic [ROW_W-1:0] row,
                                                     logic [COL_W-1:0] col);
        int base;
        int pos;
        bit hit;
        if (!row_col_ok(row, col)) return '0;
        base = (int'(row) - 1) * SLOTS_PER_ROW;
        pos  = scan_row_slots(base, col, hit);
        return hit ? shadow_vals[base + pos] : '0;
    endfunction

    function automatic t_elem_rsp apply_element(t_elem_req r);
        t_elem_rsp        res;
        int               base;
        int               pos;
        bit               hit;
        logic [VAL_W-1:0] cur;
        res.read_value   = '0;
        res.row_overflow = 1'b0;
        if (!row_col_ok(r.row, r.col)) return res;
        base = (int'(r.row) - 1) * SLOTS_PER_ROW;
        pos  = scan_row_slots(base, r.col, hit);
        cur  = hit ? shadow_vals[base + pos] : '0;
        if (r.op == OP_READ) begin
            res.read_value = cur;
            return res;
        end
        if (r.val == cur) return res;
        if (pos >= SLOTS_PER_ROW) begin
            res.row_overflow = 1'b1;
            return res;
        end
        shadow_vals[base + pos] = r.val;
        if (!hit) shadow_tags[base + pos] = r.col;
        return res;
    endfunction

    function automatic void add_case(logic op, int row, int col, logic [VAL_W-1:0] val,
                                     bit typed, logic [VAL_W-1:0] rd, logic ovf);
        t_elem_case c;
        c.req.op             = op;
        c.req.row            = ROW_W'(row);
        c.req.col            = COL_W'(col);
        c.req.val            = val;
        c.typed              = typed;
        c.rsp.read_value     = rd;
        c.rsp.row_overflow   = ovf;
        directed_cases.push_back(c);
    endfunction

    function automatic int draw_idle();
        return calm ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    task automatic send_request(t_elem_req r, bit typed, t_elem_rsp typed_rsp);
        int        gap;
        t_elem_rsp res;
        gap = draw_idle();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.operation     <= r.op;
        req_bus.row_index     <= r.row;
        req_bus.column_index  <= r.col;
        req_bus.element_value <= r.val;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        res = apply_element(r);
        expected_rsp.push_back(typed ? typed_rsp : res);
    endtask

    // response side
    initial begin
        int        stall;
        t_elem_rsp exp_rsp;
        rsp_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_rsp) begin
                hold_rsp = 0;
                rsp_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = draw_idle();
                if (stall > 0) begin
                    rsp_bus.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            rsp_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_bus.valid) @(posedge i_clk);
            if (expected_rsp.size() == 0) begin
                n_fail++;
                $error("unexpected result: read_value %h row_overflow %b",
                       rsp_bus.read_value, rsp_bus.row_overflow);
            end else begin
                exp_rsp = expected_rsp.pop_front();
                if (rsp_bus.read_value !== exp_rsp.read_value) begin
                    n_fail++;
                    $error("read_value: expected %h, got %h",
                           exp_rsp.read_value, rsp_bus.read_value);
                end
                if (rsp_bus.row_overflow !== exp_rsp.row_overflow) begin
                    n_fail++;
                    $error("row_overflow: expected %b, got %b",
                           exp_rsp.row_overflow, rsp_bus.row_overflow);
                end
            end
        end
    end

    // request side
    initial begin
        t_elem_req        r;
        t_elem_rsp        none;
        logic [ROW_W-1:0] hot_rows [N_HOT];
        int               kind;
        int               vsel;
        logic [VAL_W-1:0] ones;

        ones = '1;
        none.read_value   = '0;
        none.row_overflow = 1'b0;
        foreach (shadow_tags[k]) begin
            shadow_tags[k] = '0;
            shadow_vals[k] = '0;
        end

        i_rst_n               <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.operation     <= OP_READ;
        req_bus.row_index     <= '0;
        req_bus.column_index  <= '0;
        req_bus.element_value <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty after reset, update of a matching slot
        add_case(OP_READ,  1, 1, '0, 1'b1, '0, 1'b0);
        add_case(OP_WRITE, 1, 1, ones, 1'b1, '0, 1'b0);
        add_case(OP_READ,  1, 1, '0, 1'b1, ones, 1'b0);
        add_case(OP_WRITE, 1, 1, 64'h0123_4567_89ab_cdef, 1'b1, '0, 1'b0);
        add_case(OP_READ,  1, 1, '0, 1'b1, 64'h0123_4567_89ab_cdef, 1'b0);
        // row out of range
        add_case(OP_WRITE, 0, 5, 64'h1, 1'b1, '0, 1'b0);
        add_case(OP_READ,  0, 5, '0, 1'b1, '0, 1'b0);
        add_case(OP_WRITE, (1 << ROW_W) - 1, 5, 64'h1, 1'b1, '0, 1'b0);
        // last row, last column
        add_case(OP_WRITE, ROWS, 65535, 64'h8000_0000_0000_0001, 1'b1, '0, 1'b0);
        add_case(OP_READ,  ROWS, 65535, '0, 1'b1, 64'h8000_0000_0000_0001, 1'b0);
        // column zero
        add_case(OP_WRITE, 2, 0, 64'h3, 1'b1, '0, 1'b0);
        add_case(OP_READ,  2, 0, '0, 1'b1, '0, 1'b0);
        // zero written to an absent entry leaves the row alone
        add_case(OP_WRITE, 3, 7, '0, 1'b1, '0, 1'b0);
        add_case(OP_READ,  3, 7, '0, 1'b1, '0, 1'b0);
        // fill a row, then overflow it
        for (int s = 1; s <= SLOTS_PER_ROW; s++)
            add_case(OP_WRITE, 4, s, {$urandom, $urandom}, 1'b0, '0, 1'b0);
        add_case(OP_WRITE, 4, SLOTS_PER_ROW + 1, 64'h5, 1'b1, '0, 1'b1);
        add_case(OP_WRITE, 4, SLOTS_PER_ROW + 1, '0, 1'b1, '0, 1'b0);
        add_case(OP_READ,  4, SLOTS_PER_ROW + 1, '0, 1'b1, '0, 1'b0);

        foreach (directed_cases[k])
            send_request(directed_cases[k].req, directed_cases[k].typed,
                         directed_cases[k].rsp);

        hot_rows[0] = ROW_W'(1);
        hot_rows[1] = ROW_W'(ROWS);
        for (int j = 2; j < N_HOT; j++) hot_rows[j] = ROW_W'($urandom_range(1, ROWS));

        for (int i = 0; i < N_RANDOM; i++) begin
            calm = ((i / 150) % 4) == 3;
            if (i % 300 == 299)
                for (int j = 2; j < N_HOT; j++) hot_rows[j] = ROW_W'($urandom_range(1, ROWS));
            if (i == N_RANDOM / 4) hold_rsp = 1;
            if (i == N_RANDOM / 2) begin
                req_bus.valid <= 1'b0;
                while (expected_rsp.size() != 0) @(posedge i_clk);
            end

            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                r.row = ROW_W'($urandom);
                r.col = ($urandom_range(0, 3) == 0) ? '0 : COL_W'($urandom);
            end else if (kind < 22) begin
                r.row = ROW_W'($urandom_range(1, ROWS));
                r.col = COL_W'($urandom_range(1, 65535));
            end else begin
                r.row = hot_rows[$urandom_range(0, N_HOT - 1)];
                r.col = COL_W'($urandom_range(1, HOT_COLS));
            end
            r.op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
            vsel = $urandom_range(0, 9);
            case (vsel)
                0, 1: r.val = stored_value(r.row, r.col);
                2:    r.val = '0;
                3:    r.val = ones;
                default: r.val = {$urandom, $urandom};
            endcase
            send_request(r, 1'b0, none);
        end

        req_bus.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_fail == 0)
            $display("[sparse_row_slot_store] OK");
        else
            $display("[sparse_row_slot_store] ERROR");
        $finish;
    end

endmodule
